// ----- rtl/core/tcw_pkg.sv -----
`default_nettype none

package tcw_pkg;

   // field widths of the channels
   localparam int CMD_W       = 2;
   localparam int CHAR_W      = 8;
   localparam int ADDR_W      = 11;
   localparam int CELL_W      = 16;
   localparam int ATTR_W      = 8;
   localparam int TAB_W       = 5;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;

   // command codes
   localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_TEXT_ATTRIBUTE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAB_SIZE       = 1'd1;

   // character codes
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
   localparam logic [CHAR_W-1:0] CH_TILDE     = 8'h7E;

   // reset values and limits
   localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;
   localparam logic [CELL_W-1:0] BS_CELL    = 16'h0020;
   localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;
   localparam logic [TAB_W-1:0]  RESET_TAB  = 5'd4;
   localparam logic [TAB_W-1:0]  TAB_MAX    = 5'd16;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [CHAR_W-1:0] char_code;
      logic [ADDR_W-1:0] cell_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] cursor_address;
      logic [CELL_W-1:0] read_data;
      logic              handled;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/core/tcw_ram.sv -----
`default_nettype none

module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ----- rtl/core/text_console_writer.sv -----
// Text console writer: a ROWS x COLUMNS character cell store with a cursor.
// Request channel (req_valid/req_ready, req_item): put character, read cell
// or clear screen. Response channel (rsp_valid/rsp_ready, rsp_item): one
// item per request with the cursor's linear address, read data and handled.
// Configuration (csr_we/csr_index/csr_wdata): attribute byte and tab size,
// to be written only while the block is idle; the block does not enforce it.
// One request is worked at a time; req_ready is low until it has finished.
// Printable, return, backspace and ignored codes go through EXEC and FINISH;
// the response is registered from FINISH, which waits while a stalled
// response holds the output register. Read adds a READ state for the cell
// store's registered read port. Tab adds a TAB state for the remainder unit,
// one quotient bit a cycle. A clear sweeps all ROWS*COLUMNS cells of the
// store one cell a cycle. A newline or wrap below the last row scrolls: one
// copy a cycle through the store's read/write ports, then a blank row fill.
// After reset a clearing pass writes blanks into all ROWS*COLUMNS cells
// while req_ready stays low; csr writes are taken meanwhile.
// A stalled response stays in the output register; the next request is
// still accepted and worked, and its result waits until the register frees.
`default_nettype none

module text_console_writer
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire req_type                req_item,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rsp_type                     rsp_item,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CELLS = ROWS * COLUMNS;
   localparam int AW    = $clog2(CELLS);
   localparam int COL_W = $clog2(COLUMNS);
   localparam int ROW_W = $clog2(ROWS);
   localparam int NC_W  = $clog2(COLUMNS + 16);
   localparam int BIT_W = $clog2(COL_W);
   localparam int MOVE  = CELLS - COLUMNS;

   typedef enum logic [7:0] {
      ST_INIT   = 8'b0000_0001,
      ST_IDLE   = 8'b0000_0010,
      ST_EXEC   = 8'b0000_0100,
      ST_READ   = 8'b0000_1000,
      ST_TAB    = 8'b0001_0000,
      ST_SCROLL = 8'b0010_0000,
      ST_FILL   = 8'b0100_0000,
      ST_FINISH = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic              pend_ff, pend_in;
   logic [AW-1:0]     pend_addr_ff, pend_addr_in;
   logic [CELL_W-1:0] fill_word_ff, fill_word_in;
   logic [3:0]        rem_ff, rem_in;
   logic [BIT_W-1:0]  bit_ff, bit_in;
   logic [CELL_W-1:0] dat_ff, dat_in;
   logic              hnd_ff, hnd_in;
   logic [ATTR_W-1:0] attr_ff, attr_in;
   logic [TAB_W-1:0]  tab_ff, tab_in;

   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [CELL_W-1:0] ram_wdata;
   logic [AW-1:0]     ram_raddr;
   logic [CELL_W-1:0] ram_rdata;

   logic [AW-1:0]     cur_addr;
   logic [TAB_W-1:0]  tab_eff;
   logic              row_last;
   logic [NC_W-1:0]   col_inc;
   logic [TAB_W-1:0]  rem_try;
   logic [TAB_W-1:0]  rem_sub;
   logic [NC_W-1:0]   col_tab;
   logic              step_row;
   logic [CELL_W-1:0] attr_blank;

   // cell store
   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // cursor address and tab helpers
   always_comb begin
      cur_addr   = AW'(int'(row_ff) * COLUMNS + int'(col_ff));
      row_last   = (row_ff == ROW_W'(ROWS - 1));
      col_inc    = NC_W'(col_ff) + NC_W'(1);
      attr_blank = {attr_ff, CH_SPACE};
      if (tab_ff == '0) begin
         tab_eff = TAB_W'(1);
      end else if (tab_ff > TAB_MAX) begin
         tab_eff = TAB_MAX;
      end else begin
         tab_eff = tab_ff;
      end
      // one restoring remainder step per cycle
      rem_try = {rem_ff, col_ff[bit_ff]};
      rem_sub = (rem_try >= tab_eff) ? (rem_try - tab_eff) : rem_try;
      col_tab = NC_W'(col_ff) + NC_W'(tab_eff) - NC_W'(rem_sub);
   end

   // configuration registers
   always_comb begin
      attr_in = attr_ff;
      tab_in  = tab_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_TEXT_ATTRIBUTE: begin
               attr_in = csr_wdata;
            end
            CSR_TAB_SIZE: begin
               tab_in = csr_wdata[TAB_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      idx_in       = idx_ff;
      pend_in      = 1'b0;
      pend_addr_in = idx_ff;
      fill_word_in = fill_word_ff;
      rem_in       = rem_ff;
      bit_in       = bit_ff;
      dat_in       = dat_ff;
      hnd_in       = hnd_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      step_row     = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = idx_ff;
      ram_wdata    = fill_word_ff;
      ram_raddr    = idx_ff + AW'(COLUMNS);

      case (state_ff)
         ST_INIT: begin
            ram_we    = 1'b1;
            ram_wdata = RESET_CELL;
            if (idx_ff == AW'(CELLS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_item;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            dat_in   = '0;
            hnd_in   = 1'b1;
            state_in = ST_FINISH;
            ram_raddr = AW'(req_ff.cell_address);
            case (req_ff.cmd)
               CMD_PUT: begin
                  case (req_ff.char_code)
                     CH_BACKSPACE: begin
                        if (col_ff == '0) begin
                           hnd_in = 1'b0;
                        end else begin
                           ram_we    = 1'b1;
                           ram_waddr = cur_addr;
                           ram_wdata = BS_CELL;
                           col_in    = col_ff - 1'b1;
                        end
                     end
                     CH_TAB: begin
                        rem_in   = '0;
                        bit_in   = BIT_W'(COL_W - 1);
                        state_in = ST_TAB;
                     end
                     CH_RETURN: begin
                        col_in = '0;
                     end
                     CH_NEWLINE: begin
                        col_in   = '0;
                        step_row = 1'b1;
                     end
                     default: begin
                        if (req_ff.char_code inside {[CH_SPACE:CH_TILDE]}) begin
                           ram_we    = 1'b1;
                           ram_waddr = cur_addr;
                           ram_wdata = {attr_ff, req_ff.char_code};
                           if (col_inc >= NC_W'(COLUMNS)) begin
                              col_in   = '0;
                              step_row = 1'b1;
                           end else begin
                              col_in = COL_W'(col_inc);
                           end
                        end else begin
                           hnd_in = 1'b0;
                        end
                     end
                  endcase
               end
               CMD_READ: begin
                  state_in = ST_READ;
               end
               CMD_CLEAR: begin
                  idx_in       = '0;
                  fill_word_in = attr_blank;
                  state_in     = ST_FILL;
               end
               default: begin
                  hnd_in = 1'b0;
               end
            endcase
         end
         ST_READ: begin
            dat_in   = (int'(req_ff.cell_address) < CELLS) ? ram_rdata : '0;
            state_in = ST_FINISH;
         end
         ST_TAB: begin
            rem_in = rem_sub[3:0];
            bit_in = bit_ff - 1'b1;
            if (bit_ff == '0) begin
               state_in = ST_FINISH;
               if (col_tab >= NC_W'(COLUMNS)) begin
                  col_in   = '0;
                  step_row = 1'b1;
               end else begin
                  col_in = COL_W'(col_tab);
               end
            end
         end
         ST_SCROLL: begin
            // read the cell one row below, write it into the current cell in the next cycle
            ram_we    = pend_ff;
            ram_waddr = pend_addr_ff;
            ram_wdata = ram_rdata;
            if (idx_ff == AW'(MOVE)) begin
               fill_word_in = attr_blank;
               state_in     = ST_FILL;
            end else begin
               pend_in = 1'b1;
               idx_in  = idx_ff + 1'b1;
            end
         end
         ST_FILL: begin
            ram_we = 1'b1;
            if (idx_ff == AW'(CELLS - 1)) begin
               state_in = ST_FINISH;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in          = 1'b1;
               rsp_in.cursor_address = ADDR_W'(cur_addr);
               rsp_in.read_data      = dat_ff;
               rsp_in.handled        = hnd_ff;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // row advance, scrolling past the last row
      if (step_row) begin
         if (row_last) begin
            idx_in   = '0;
            state_in = ST_SCROLL;
         end else begin
            row_in = row_ff + 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         attr_ff      <= RESET_ATTR;
         tab_ff       <= RESET_TAB;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         attr_ff      <= attr_in;
         tab_ff       <= tab_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      rsp_ff       <= rsp_in;
      pend_addr_ff <= pend_addr_in;
      fill_word_ff <= fill_word_in;
      rem_ff       <= rem_in;
      bit_ff       <= bit_in;
      dat_ff       <= dat_in;
      hnd_ff       <= hnd_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

`default_nettype wire

// ----- rtl/core/tcw_checker.sv -----
`default_nettype none

module tcw_checker
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_item
);

   localparam int CELLS = ROWS * COLUMNS;

   // reset starts the clearing pass with nothing to report
   assert property (@(posedge clock) reset |=> !req_ready && !rsp_valid)
      else $error("ready or response right after reset");

   // accepting an item always drops ready
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready again right after accept");

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("stalled response changed");

   // an ignored item never carries read data
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.handled |-> rsp_item.read_data == '0)
      else $error("read data on ignored item");

   // cursor stays inside the screen
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (CELLS > 2048) || (int'(rsp_item.cursor_address) < CELLS))
      else $error("cursor address out of range");

endmodule

bind text_console_writer tcw_checker #(
   .COLUMNS (COLUMNS),
   .ROWS    (ROWS)
) u_tcw_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_item  (rsp_item)
);

`default_nettype wire
